### rtl/tbp_pkg.sv
package tbp_pkg;

	// default table sizing limits
	localparam int MAX_GLOBAL_BITS   = 13;
	localparam int MAX_LOCAL_BITS    = 11;
	localparam int MAX_PC_INDEX_BITS = 11;

	// configuration port
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;
	localparam int CFG_W  = 4;
	localparam int BITS_W = 5;

	localparam logic [CFG_W-1:0] GLOBAL_BITS_RST = 4'd9;
	localparam logic [CFG_W-1:0] LOCAL_BITS_RST  = 4'd10;
	localparam logic [CFG_W-1:0] PC_BITS_RST     = 4'd10;

	typedef enum logic [1:0] {
		REG_GLOBAL_BITS = 2'd0,
		REG_LOCAL_BITS  = 2'd1,
		REG_PC_BITS     = 2'd2
	} cfg_reg_t;

	// stream payload widths
	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 8;

	// result queue
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;

	// 2-bit saturating counters
	typedef logic [1:0] ctr_t;
	localparam ctr_t CTR_INIT = 2'd1;
	localparam ctr_t CTR_MAX  = 2'd3;
	localparam ctr_t CTR_MIN  = 2'd0;

	function automatic ctr_t ctr_train(input ctr_t c, input logic up);
		ctr_t r;
		r = c;
		if (up) begin
			if (c != CTR_MAX) r = c + 2'd1;
		end else begin
			if (c != CTR_MIN) r = c - 2'd1;
		end
		return r;
	endfunction

	// clamp a length register into 1..max
	function automatic logic [BITS_W-1:0] clamp_bits(input logic [CFG_W-1:0] v,
			input logic [BITS_W-1:0] maxv);
		logic [BITS_W-1:0] r;
		r = BITS_W'(v);
		if (v == '0) r = BITS_W'(1);
		else if (BITS_W'(v) > maxv) r = maxv;
		return r;
	endfunction

endpackage

### rtl/tournament_branch_predictor.sv
// channel   | dir | transaction contents
// ----------+-----+--------------------------------------------------------
// s_axis    | in  | one resolved branch: pc, outcome
// m_axis    | out | prediction made before training: prediction, used_local
// apb       | in  | table sizing registers (global, local, pc index lengths)
//
// one branch per cycle while s_axis_tready is high; local history is read as
// the input transaction is accepted, the local counter in stage 1, and the
// counter update and result queue write are done in stage 2, after which the result is offered.
// after reset a clearing pass sweeps all tables with a counter of
// max(MAX_GLOBAL_BITS, MAX_LOCAL_BITS, MAX_PC_INDEX_BITS) bits, with
// s_axis_tready low; register writes are taken during the pass.
// a four-entry result queue with credit count decouples m_axis stalls;
// outside the clearing pass, s_axis_tready drops only when four results are queued or in flight.
module tournament_branch_predictor #(
	parameter int MAX_GLOBAL_BITS   = tbp_pkg::MAX_GLOBAL_BITS,
	parameter int MAX_LOCAL_BITS    = tbp_pkg::MAX_LOCAL_BITS,
	parameter int MAX_PC_INDEX_BITS = tbp_pkg::MAX_PC_INDEX_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// branch input
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [tbp_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // pc[31:0], outcome[32], zero pad
	// prediction output
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [tbp_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // prediction[0], used_local[1], zero pad
	// configuration
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [tbp_pkg::ADDR_W-1:0]     paddr,
	input  logic [tbp_pkg::DATA_W-1:0]     pwdata,
	output logic [tbp_pkg::DATA_W-1:0]     prdata,
	output logic                           pready
);

	localparam int GW = MAX_GLOBAL_BITS;
	localparam int LW = MAX_LOCAL_BITS;
	localparam int PW = MAX_PC_INDEX_BITS;
	localparam int GL_MAX = (GW > LW) ? GW : LW;
	localparam int CLR_BITS = (GL_MAX > PW) ? GL_MAX : PW;
	localparam int G_DEPTH = 1 << GW;
	localparam int L_DEPTH = 1 << LW;
	localparam int P_DEPTH = 1 << PW;
	localparam int CNT_W = tbp_pkg::FIFO_AW + 1;

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	logic [tbp_pkg::CFG_W-1:0] ghb_q, lhb_q, pcb_q;
	logic                      cfg_wr;
	tbp_pkg::cfg_reg_t         cfg_sel;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign cfg_sel = tbp_pkg::cfg_reg_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ghb_q <= tbp_pkg::GLOBAL_BITS_RST;
			lhb_q <= tbp_pkg::LOCAL_BITS_RST;
			pcb_q <= tbp_pkg::PC_BITS_RST;
		end else if (cfg_wr) begin
			case (cfg_sel)
				tbp_pkg::REG_GLOBAL_BITS: ghb_q <= pwdata[tbp_pkg::CFG_W-1:0];
				tbp_pkg::REG_LOCAL_BITS:  lhb_q <= pwdata[tbp_pkg::CFG_W-1:0];
				tbp_pkg::REG_PC_BITS:     pcb_q <= pwdata[tbp_pkg::CFG_W-1:0];
				default: ;  // unmapped address, write dropped
			endcase
		end
	end

	always_comb begin
		case (cfg_sel)
			tbp_pkg::REG_GLOBAL_BITS: prdata = tbp_pkg::DATA_W'(ghb_q);
			tbp_pkg::REG_LOCAL_BITS:  prdata = tbp_pkg::DATA_W'(lhb_q);
			tbp_pkg::REG_PC_BITS:     prdata = tbp_pkg::DATA_W'(pcb_q);
			default:                  prdata = '0;
		endcase
	end

	// effective lengths and index masks
	logic [tbp_pkg::BITS_W-1:0] gbits, lbits, pbits;
	logic [GW-1:0] gmask;
	logic [LW-1:0] lmask;
	logic [PW-1:0] pmask;

	assign gbits = tbp_pkg::clamp_bits(ghb_q, tbp_pkg::BITS_W'(GW));
	assign lbits = tbp_pkg::clamp_bits(lhb_q, tbp_pkg::BITS_W'(LW));
	assign pbits = tbp_pkg::clamp_bits(pcb_q, tbp_pkg::BITS_W'(PW));

	always_comb begin
		for (int i = 0; i < GW; i++) gmask[i] = (tbp_pkg::BITS_W'(i) < gbits);
		for (int i = 0; i < LW; i++) lmask[i] = (tbp_pkg::BITS_W'(i) < lbits);
		for (int i = 0; i < PW; i++) pmask[i] = (tbp_pkg::BITS_W'(i) < pbits);
	end

	// ------------------------------------------------------------------
	// post-reset clearing pass
	// ------------------------------------------------------------------
	logic                clearing_q;
	logic [CLR_BITS-1:0] clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_q      <= '0;
		end else if (clearing_q) begin
			clr_q <= clr_q + 1'b1;
			if (&clr_q) clearing_q <= 1'b0;
		end
	end

	// ------------------------------------------------------------------
	// input side: credit check, global history, table indices
	// ------------------------------------------------------------------
	logic [CNT_W-1:0] credit_q;
	logic             s_fire, m_fire;
	logic [31:0]      in_pc;
	logic             in_outcome;
	logic [GW-1:0]    ghist_q, gh_shift, gidx_in;
	logic [PW-1:0]    pidx_in;

	assign s_axis_tready = !clearing_q && (credit_q < CNT_W'(tbp_pkg::FIFO_DEPTH));
	assign s_fire        = s_axis_tvalid & s_axis_tready;
	assign in_pc         = s_axis_tdata[31:0];
	assign in_outcome    = s_axis_tdata[32];
	assign gidx_in       = ghist_q & gmask;
	assign pidx_in       = in_pc[PW-1:0] & pmask;

	always_comb begin
		gh_shift    = ghist_q << 1;
		gh_shift[0] = in_outcome;
	end

	// global history depends only on the outcome, so it moves at the input
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ghist_q <= '0;
		else if (s_fire) ghist_q <= gh_shift & gmask;
	end

	// ------------------------------------------------------------------
	// pipeline registers
	// ------------------------------------------------------------------
	logic           valid_s1, valid_s2;
	logic [PW-1:0]  pidx_s1, pidx_s2;
	logic [GW-1:0]  gidx_s1, gidx_s2;
	logic           outcome_s1, outcome_s2;
	logic [LW-1:0]  lht_rd_s1;
	tbp_pkg::ctr_t  gctr_rd_s1, chs_rd_s1;
	logic [LW-1:0]  lhist_s1, lhist_s2, lht_new_s1, lht_new_s2;
	tbp_pkg::ctr_t  gctr_cur_s1, chs_cur_s1;
	tbp_pkg::ctr_t  gctr_s2, chs_s2, lctr_rd_s2, lfwd_val_s2;
	logic           lfwd_s2;

	// last counter write for the global-indexed tables
	logic           wr_valid_q;
	logic [GW-1:0]  wr_gidx_q;
	tbp_pkg::ctr_t  wr_gctr_q, wr_chs_q;

	// stage 2 results
	tbp_pkg::ctr_t  lctr_cur, lctr_new, gctr_new, chs_new;
	logic           lpred, gpred, use_local, pred;

	// stage 1: finish the local history with forwarding from the branch ahead,
	// and fold in counter writes the table reads could not yet see
	always_comb begin
		if (valid_s2 && pidx_s2 == pidx_s1) lhist_s1 = lht_new_s2 & lmask;
		else                                lhist_s1 = lht_rd_s1 & lmask;
		lht_new_s1    = lhist_s1 << 1;
		lht_new_s1[0] = outcome_s1;
		lht_new_s1    = lht_new_s1 & lmask;

		if (valid_s2 && gidx_s2 == gidx_s1) begin
			gctr_cur_s1 = gctr_new;
			chs_cur_s1  = chs_new;
		end else if (wr_valid_q && wr_gidx_q == gidx_s1) begin
			gctr_cur_s1 = wr_gctr_q;
			chs_cur_s1  = wr_chs_q;
		end else begin
			gctr_cur_s1 = gctr_rd_s1;
			chs_cur_s1  = chs_rd_s1;
		end
	end

	// stage 2: predict and train
	always_comb begin
		lctr_cur  = lfwd_s2 ? lfwd_val_s2 : lctr_rd_s2;
		lpred     = lctr_cur[1];
		gpred     = gctr_s2[1];
		use_local = chs_s2[1];
		pred      = use_local ? lpred : gpred;
		lctr_new  = tbp_pkg::ctr_train(lctr_cur, outcome_s2);
		gctr_new  = tbp_pkg::ctr_train(gctr_s2, outcome_s2);
		// chooser moves only when the sides disagree
		if (lpred != gpred) chs_new = tbp_pkg::ctr_train(chs_s2, lpred == outcome_s2);
		else                chs_new = chs_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			wr_valid_q <= 1'b0;
		end else begin
			valid_s1 <= s_fire;
			valid_s2 <= valid_s1;
			if (valid_s2) wr_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			pidx_s1    <= pidx_in;
			gidx_s1    <= gidx_in;
			outcome_s1 <= in_outcome;
		end
		if (valid_s1) begin
			pidx_s2     <= pidx_s1;
			gidx_s2     <= gidx_s1;
			outcome_s2  <= outcome_s1;
			lhist_s2    <= lhist_s1;
			lht_new_s2  <= lht_new_s1;
			gctr_s2     <= gctr_cur_s1;
			chs_s2      <= chs_cur_s1;
			// branch ahead writes the same local counter at this edge
			lfwd_s2     <= valid_s2 && (lhist_s2 == lhist_s1);
			lfwd_val_s2 <= lctr_new;
		end
		if (valid_s2) begin
			wr_gidx_q <= gidx_s2;
			wr_gctr_q <= gctr_new;
			wr_chs_q  <= chs_new;
		end
	end

	// ------------------------------------------------------------------
	// tables
	// ------------------------------------------------------------------
	logic [LW-1:0]  lht_mem  [P_DEPTH];
	tbp_pkg::ctr_t  lctr_mem [L_DEPTH];
	tbp_pkg::ctr_t  gctr_mem [G_DEPTH];
	tbp_pkg::ctr_t  chs_mem  [G_DEPTH];

	// local history table: read at input, written in stage 1
	always_ff @(posedge clk) begin
		if (clearing_q) lht_mem[clr_q[PW-1:0]] <= '0;
		else if (valid_s1) lht_mem[pidx_s1] <= lht_new_s1;
		if (s_fire) lht_rd_s1 <= lht_mem[pidx_in];
	end

	// local counters: read in stage 1, written in stage 2
	always_ff @(posedge clk) begin
		if (clearing_q) lctr_mem[clr_q[LW-1:0]] <= tbp_pkg::CTR_INIT;
		else if (valid_s2) lctr_mem[lhist_s2] <= lctr_new;
		if (valid_s1) lctr_rd_s2 <= lctr_mem[lhist_s1];
	end

	// global counters: read at input, written in stage 2
	always_ff @(posedge clk) begin
		if (clearing_q) gctr_mem[clr_q[GW-1:0]] <= tbp_pkg::CTR_INIT;
		else if (valid_s2) gctr_mem[gidx_s2] <= gctr_new;
		if (s_fire) gctr_rd_s1 <= gctr_mem[gidx_in];
	end

	// chooser counters: same indexing as the global counters
	always_ff @(posedge clk) begin
		if (clearing_q) chs_mem[clr_q[GW-1:0]] <= tbp_pkg::CTR_INIT;
		else if (valid_s2) chs_mem[gidx_s2] <= chs_new;
		if (s_fire) chs_rd_s1 <= chs_mem[gidx_in];
	end

	// ------------------------------------------------------------------
	// result queue
	// ------------------------------------------------------------------
	logic [1:0]       fifo_q [tbp_pkg::FIFO_DEPTH];
	logic [CNT_W-1:0] wptr_q, rptr_q;

	assign m_axis_tvalid = (wptr_q != rptr_q);
	assign m_fire        = m_axis_tvalid & m_axis_tready;
	assign m_axis_tdata  = tbp_pkg::OUT_DATA_W'(fifo_q[rptr_q[tbp_pkg::FIFO_AW-1:0]]);

	always_ff @(posedge clk) begin
		if (valid_s2) fifo_q[wptr_q[tbp_pkg::FIFO_AW-1:0]] <= {use_local, pred};
	end

	// credits count queued plus in-flight transactions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q   <= '0;
			rptr_q   <= '0;
			credit_q <= '0;
		end else begin
			if (valid_s2) wptr_q <= wptr_q + 1'b1;
			if (m_fire) rptr_q <= rptr_q + 1'b1;
			if (s_fire && !m_fire) credit_q <= credit_q + 1'b1;
			else if (!s_fire && m_fire) credit_q <= credit_q - 1'b1;
		end
	end

endmodule

### bench/tbp_checker.sv
`timescale 1ns / 100ps

module tbp_checker
	import tbp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	input  logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // pc[31:0], outcome[32], zero pad
	input  logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	input  logic [OUT_DATA_W-1:0] m_axis_tdata,  // prediction[0], used_local[1], zero pad
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic                  pready,
	input  logic [ADDR_W-1:0]     paddr,
	input  logic [DATA_W-1:0]     pwdata,
	output int                    mismatches,
	output int                    pending
);

	localparam int GLOBAL_ENTRIES = 1 << MAX_GLOBAL_BITS;
	localparam int LOCAL_ENTRIES  = 1 << MAX_LOCAL_BITS;
	localparam int PC_ENTRIES     = 1 << MAX_PC_INDEX_BITS;

	typedef struct packed {
		logic prediction;
		logic used_local;
	} branch_result_t;

	logic [CFG_W-1:0]           global_len_reg;
	logic [CFG_W-1:0]           local_len_reg;
	logic [CFG_W-1:0]           pc_len_reg;
	logic [MAX_GLOBAL_BITS-1:0] global_hist;
	logic [MAX_LOCAL_BITS-1:0]  local_hist [PC_ENTRIES];
	ctr_t                       local_ctr  [LOCAL_ENTRIES];
	ctr_t                       global_ctr [GLOBAL_ENTRIES];
	ctr_t                       choice_ctr [GLOBAL_ENTRIES];
	branch_result_t             predicted_q [$];
	int                         error_count;

	function automatic logic [31:0] len_mask(input logic [CFG_W-1:0] len, input int max_len);
		int n;
		n = (len == '0) ? 1 : ((int'(len) > max_len) ? max_len : int'(len));
		return (32'd1 << n) - 32'd1;
	endfunction

	function automatic ctr_t bump(input ctr_t c, input logic up);
		if (up)
			return (c == 2'd3) ? c : c + 2'd1;
		return (c == 2'd0) ? c : c - 2'd1;
	endfunction

	// lookup first, then train with the same indices
	function automatic branch_result_t predict_and_train(input logic [31:0] pc,
			input logic taken);
		logic [31:0]    gmask, lmask, pmask;
		logic [31:0]    gidx, pidx, lidx;
		logic           gpred, lpred;
		branch_result_t r;
		gmask = len_mask(global_len_reg, MAX_GLOBAL_BITS);
		lmask = len_mask(local_len_reg, MAX_LOCAL_BITS);
		pmask = len_mask(pc_len_reg, MAX_PC_INDEX_BITS);
		gidx  = 32'(global_hist) & gmask;
		pidx  = pc & pmask;
		lidx  = 32'(local_hist[pidx]) & lmask;
		gpred = global_ctr[gidx][1];
		lpred = local_ctr[lidx][1];
		r.used_local = choice_ctr[gidx][1];
		r.prediction = r.used_local ? lpred : gpred;
		if (lpred != gpred)
			choice_ctr[gidx] = bump(choice_ctr[gidx], lpred == taken);
		local_ctr[lidx]  = bump(local_ctr[lidx], taken);
		local_hist[pidx] = MAX_LOCAL_BITS'(((lidx << 1) | 32'(taken)) & lmask);
		global_ctr[gidx] = bump(global_ctr[gidx], taken);
		global_hist      = MAX_GLOBAL_BITS'(((gidx << 1) | 32'(taken)) & gmask);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		branch_result_t got, want;
		if (!arst_n) begin
			global_len_reg = GLOBAL_BITS_RST;
			local_len_reg  = LOCAL_BITS_RST;
			pc_len_reg     = PC_BITS_RST;
			global_hist    = '0;
			for (int i = 0; i < PC_ENTRIES; i++) local_hist[i] = '0;
			for (int i = 0; i < LOCAL_ENTRIES; i++) local_ctr[i] = CTR_INIT;
			for (int i = 0; i < GLOBAL_ENTRIES; i++) begin
				global_ctr[i] = CTR_INIT;
				choice_ctr[i] = CTR_INIT;
			end
			predicted_q.delete();
			error_count = 0;
			mismatches <= 0;
			pending    <= 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00) begin
				case (cfg_reg_t'(paddr[ADDR_W-1:2]))
					REG_GLOBAL_BITS: global_len_reg = pwdata[CFG_W-1:0];
					REG_LOCAL_BITS:  local_len_reg  = pwdata[CFG_W-1:0];
					REG_PC_BITS:     pc_len_reg     = pwdata[CFG_W-1:0];
					default: ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.prediction = m_axis_tdata[0];
				got.used_local = m_axis_tdata[1];
				if (predicted_q.size() == 0) begin
					$error("result transaction with no prediction pending");
					error_count++;
				end else begin
					want = predicted_q.pop_front();
					if (got.prediction !== want.prediction) begin
						$error("prediction: expected %0b, actual %0b",
							want.prediction, got.prediction);
						error_count++;
					end
					if (got.used_local !== want.used_local) begin
						$error("used_local: expected %0b, actual %0b",
							want.used_local, got.used_local);
						error_count++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				predicted_q.push_back(predict_and_train(s_axis_tdata[31:0], s_axis_tdata[32]));
			mismatches <= error_count;
			pending    <= predicted_q.size();
		end
	end

endmodule

### bench/tb.sv
`timescale 1ns / 100ps

module tb;
	import tbp_pkg::*;

	// rough share of idle cycles on each side, in percent
	localparam int IDLE_PCT    = 28;
	// long receiver hold-off, enough to fill the four result credits
	localparam int HOLD_CYCLES = 60;
	localparam int POOL_SIZE   = 8;
	// watchdog limit; a correct run, clearing pass included, ends well before it
	localparam int CYCLE_LIMIT = 200000;
	// word address that maps to no register
	localparam logic [ADDR_W-1:0] ADDR_UNMAPPED = 4'd12;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;   // pc[31:0], outcome[32], zero pad
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;   // prediction[0], used_local[1], zero pad
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [ADDR_W-1:0]     paddr;
	logic [DATA_W-1:0]     pwdata;
	logic [DATA_W-1:0]     prdata;
	logic                  pready;

	int   mismatches;
	int   pending;
	// set by the stimulus; calm is read by both sides, hold_req by the receiver
	logic calm;
	int   hold_req;

	tournament_branch_predictor DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	// watches both streams and the register port, predicts and compares
	tbp_checker scoreboard (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.pready        (pready),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.mismatches    (mismatches),
		.pending       (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// cycle counter that ends a hung run
	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	// result side: random back-pressure, calm stretches, and on request a
	// long hold-off counted here so the block fills up and stalls its input
	initial begin : receiver
		int holds_done;
		holds_done = 0;
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req != holds_done) begin
				holds_done++;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else
				m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	function automatic logic [ADDR_W-1:0] reg_addr(input cfg_reg_t r);
		return ADDR_W'({r, 2'b00});
	endfunction

	// setup then access phase; psel stays up so writes can run back to back
	task automatic reg_write(input logic [ADDR_W-1:0] addr, input logic [CFG_W-1:0] value);
		logic [DATA_W-1:0] junk;
		junk = $urandom;
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= addr;
		// upper bits carry noise, only the low nibble is a length
		pwdata  <= {junk[DATA_W-1:CFG_W], value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	// offer one branch transaction, with random gaps unless calm
	task automatic send_branch(input logic [31:0] pc, input logic taken);
		if (!calm && $urandom_range(99) < IDLE_PCT) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while (!calm && $urandom_range(99) < IDLE_PCT);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= IN_DATA_W'({taken, pc});
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// stop offering and wait for every outstanding prediction
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// tables keep their contents across a change of lengths
	task automatic configure(input logic [CFG_W-1:0] g, input logic [CFG_W-1:0] l,
			input logic [CFG_W-1:0] p);
		drain();
		reg_write(reg_addr(REG_GLOBAL_BITS), g);
		reg_write(reg_addr(REG_LOCAL_BITS), l);
		reg_write(reg_addr(REG_PC_BITS), p);
		// a write to an unmapped address must change nothing
		reg_write(ADDR_UNMAPPED, CFG_W'($urandom));
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// mostly recurring branches with periodic outcomes, so counters saturate
	// and the chooser gets pulled both ways; the rest is random noise
	task automatic run_traffic(input int count);
		logic [31:0] pool_pc  [POOL_SIZE];
		logic [7:0]  pool_pat [POOL_SIZE];
		int          pool_len [POOL_SIZE];
		int          pool_pos [POOL_SIZE];
		int          i, k;
		for (i = 0; i < POOL_SIZE; i++) begin
			pool_pc[i]  = $urandom;
			pool_pat[i] = 8'($urandom);
			pool_len[i] = $urandom_range(8, 1);
			pool_pos[i] = 0;
		end
		for (i = 0; i < count; i++) begin
			if ($urandom_range(99) < 80) begin
				k = $urandom_range(POOL_SIZE - 1);
				send_branch(pool_pc[k], pool_pat[k][pool_pos[k]]);
				pool_pos[k] = (pool_pos[k] + 1) % pool_len[k];
			end else
				send_branch($urandom, 1'($urandom_range(1)));
		end
	endtask

	initial begin : stimulus
		int i;
		arst_n        = 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		psel          <= 1'b0;
		penable       <= 1'b0;
		pwrite        <= 1'b0;
		paddr         <= '0;
		pwdata        <= '0;
		calm          <= 1'b0;
		hold_req      <= 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed part under the reset lengths: pc extremes, both outcomes,
		// saturation toward taken, then an alternating branch
		repeat (4) send_branch(32'h0000_0000, 1'b1);
		repeat (2) send_branch(32'hFFFF_FFFF, 1'b0);
		send_branch(32'h5555_5555, 1'b1);
		send_branch(32'hAAAA_AAAA, 1'b0);
		for (i = 0; i < 12; i++)
			send_branch(32'h0000_0400, i[0]);

		// largest tables; long result hold-off while branches keep coming
		configure(4'd13, 4'd11, 4'd11);
		run_traffic(20);
		hold_req <= hold_req + 1;
		run_traffic(110);

		// smallest tables
		configure(4'd1, 4'd1, 4'd1);
		run_traffic(100);

		// zero lengths behave as one
		configure(4'd0, 4'd0, 4'd0);
		run_traffic(100);

		// lengths above the limits are clamped; no idling on either side
		configure(4'd15, 4'd15, 4'd15);
		calm <= 1'b1;
		run_traffic(120);
		calm <= 1'b0;

		// mid-size lengths, with a full pause halfway through
		configure(4'd4, 4'd3, 4'd2);
		run_traffic(50);
		drain();
		run_traffic(50);

		// mixed extremes
		configure(4'd13, 4'd1, 4'd11);
		run_traffic(100);
		configure(4'd1, 4'd11, 4'd1);
		run_traffic(100);

		// random lengths, full register range
		for (i = 0; i < 3; i++) begin
			configure(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom));
			run_traffic(60);
		end

		drain();
		// leave room for a stray transaction
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

### files.f
rtl/tbp_pkg.sv
rtl/tournament_branch_predictor.sv
bench/tbp_checker.sv
bench/tb.sv
